@@ hw/rtl/lcpi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcpi_pkg
// Types and constants shared by the load current regulator.
// ----------------------------------------------------------------------------
package lcpi_pkg;

  localparam int TARGET_W  = 12;
  localparam int MEAS_W    = 16;
  localparam int VOLT_W    = 16;
  localparam int DAC_W     = 8;
  localparam int CHARGE_W  = 32;
  localparam int POWER_W   = 28;
  localparam int OFFSET_W  = 12;
  localparam int INTEG_W   = 28;
  localparam int MAG_W     = 27;   // |integral| <= 2^26
  localparam int MAG5_W    = 29;   // 5 * |integral|
  localparam int QUOT_W    = 27;   // 5 * |integral| / 3
  localparam int RECIP_W   = 30;
  localparam int RECIP_SHIFT = 31;
  localparam int SP_W      = 29;   // signed setpoint before clamp
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;

  localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 28'sd67108864;
  // ceil(2^31 / 3), exact floor division for values below 2^31
  localparam logic [RECIP_W-1:0] RECIP_3 = 30'd715827883;
  localparam logic [DAC_W-1:0]   DAC_MAX = 8'd255;

  localparam logic [VOLT_W-1:0]   MIN_SOURCE_RST  = 16'd2000;
  localparam logic [POWER_W-1:0]  POWER_LIMIT_RST = 28'd15000000;
  localparam logic [OFFSET_W-1:0] OFFSET_RST      = 12'd2000;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SOURCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 2'd2;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [TARGET_W-1:0]      target_current_ma;
    logic signed [MEAS_W-1:0] measured_current_mv;
    logic [VOLT_W-1:0]        source_voltage_mv;
    cmd_t                     command;
  } tick_t;

  typedef struct packed {
    logic [DAC_W-1:0]    coarse_dac;
    logic [DAC_W-1:0]    fine_dac;
    logic                output_on;
    logic [CHARGE_W-1:0] charge_total;
  } result_t;

  // control stage results handed to the setpoint stages
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic                integ_neg;
    logic [MAG5_W-1:0]   integ_mag5;
    logic                output_on;
    logic [CHARGE_W-1:0] charge;
  } ctl_t;

endpackage

@@ hw/rtl/lcpi_tick_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcpi_tick_if
// Request channel: one control tick per request.
// ----------------------------------------------------------------------------
interface lcpi_tick_if;
  logic            valid;
  logic            ready;
  lcpi_pkg::tick_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/lcpi_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcpi_result_if
// Result channel: DAC codes, output state and charge total per tick.
// ----------------------------------------------------------------------------
interface lcpi_result_if;
  logic              valid;
  logic              ready;
  lcpi_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/lcpi_setpoint.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcpi_setpoint
// Scales the integral by 5/3, forms the clamped setpoint and splits it into
// coarse and fine DAC codes. Two register stages, advancing together.
// ----------------------------------------------------------------------------
module lcpi_setpoint (
  input  logic                              clk,
  input  logic                              advance,
  input  lcpi_pkg::ctl_t                    ctl,
  input  logic [lcpi_pkg::OFFSET_W-1:0]     offset,
  output lcpi_pkg::result_t                 result
);

  logic [lcpi_pkg::MAG5_W+lcpi_pkg::RECIP_W-1:0] prod;
  logic [lcpi_pkg::QUOT_W-1:0]   quot;
  logic [lcpi_pkg::TARGET_W-1:0] target;
  logic                          integ_neg;
  logic                          output_on;
  logic [lcpi_pkg::CHARGE_W-1:0] charge;

  logic signed [lcpi_pkg::SP_W-1:0] sp;
  logic [lcpi_pkg::SP_W-2:0]        sp_pos;
  logic [lcpi_pkg::SP_W-2:0]        rem;
  logic [lcpi_pkg::DAC_W-1:0]       coarse;
  logic [lcpi_pkg::DAC_W-1:0]       fine;
  lcpi_pkg::result_t                result_next;

  // divide by 3 as multiply by reciprocal
  assign prod = {{lcpi_pkg::RECIP_W{1'b0}}, ctl.integ_mag5}
              * {{lcpi_pkg::MAG5_W{1'b0}}, lcpi_pkg::RECIP_3};

  always_ff @(posedge clk) begin
    if (advance) begin
      quot      <= prod[lcpi_pkg::RECIP_SHIFT +: lcpi_pkg::QUOT_W];
      target    <= ctl.target;
      integ_neg <= ctl.integ_neg;
      output_on <= ctl.output_on;
      charge    <= ctl.charge;
    end
  end

  always_comb begin
    // quotient of the magnitude, so truncation is toward zero
    sp = $signed({{(lcpi_pkg::SP_W-lcpi_pkg::TARGET_W){1'b0}}, target})
       + $signed({{(lcpi_pkg::SP_W-lcpi_pkg::OFFSET_W){1'b0}}, offset});
    if (integ_neg) begin
      sp = sp - $signed({{(lcpi_pkg::SP_W-lcpi_pkg::QUOT_W){1'b0}}, quot});
    end else begin
      sp = sp + $signed({{(lcpi_pkg::SP_W-lcpi_pkg::QUOT_W){1'b0}}, quot});
    end
    sp_pos = sp[lcpi_pkg::SP_W-1] ? '0 : sp[lcpi_pkg::SP_W-2:0];

    if (sp_pos[lcpi_pkg::SP_W-2:12] != '0) begin
      coarse = lcpi_pkg::DAC_MAX;
    end else begin
      coarse = sp_pos[11:4];
    end
    rem = sp_pos - {{(lcpi_pkg::SP_W-1-lcpi_pkg::DAC_W-4){1'b0}}, coarse, 4'b0000};
    if (rem[lcpi_pkg::SP_W-2:10] != '0) begin
      fine = lcpi_pkg::DAC_MAX;
    end else begin
      fine = rem[9:2];
    end

    result_next.coarse_dac   = output_on ? coarse : '0;
    result_next.fine_dac     = output_on ? fine : '0;
    result_next.output_on    = output_on;
    result_next.charge_total = charge;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

@@ hw/rtl/load_current_pi_regulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_current_pi_regulator
// Feed-forward plus integral current regulator for an electronic load.
// ----------------------------------------------------------------------------
// Takes one request per clock while not stalled and returns its result
// through a three-stage pipeline: the control stage (command, integral,
// shutdown checks, charge total), the 5/3 integral scaling multiply, and the
// setpoint clamp and DAC split in the result register. The integral and
// enable state close their loop in the control stage, so back-to-back
// requests see each other's state. The whole pipeline holds while a result
// waits to be taken, and ready drops only then. Write the configuration
// registers only while no request is in flight: the offset is applied in
// the last stage, as the result register loads.
module load_current_pi_regulator #(
  parameter int ACCUM_TICKS = 100
) (
  input  logic                              clk,
  input  logic                              rst,
  lcpi_tick_if.sink                         tick,
  lcpi_result_if.source                     result,
  input  logic                              cfg_we,
  input  logic [lcpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcpi_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int TICK_W = $clog2(ACCUM_TICKS + 1);

  logic [lcpi_pkg::VOLT_W-1:0]   min_source_mv;
  logic [lcpi_pkg::POWER_W-1:0]  power_limit;
  logic [lcpi_pkg::OFFSET_W-1:0] setpoint_offset_mv;

  logic                                 enabled;
  logic signed [lcpi_pkg::INTEG_W-1:0]  integral;
  logic [TICK_W-1:0]                    tick_cnt;
  logic [lcpi_pkg::CHARGE_W-1:0]        charge;

  logic                                 enabled_next;
  logic signed [lcpi_pkg::INTEG_W-1:0]  integral_next;
  logic [TICK_W-1:0]                    tick_cnt_next;
  logic [lcpi_pkg::CHARGE_W-1:0]        charge_next;

  logic                                 en_cmd;
  logic [lcpi_pkg::CHARGE_W-1:0]        charge_base;
  logic [lcpi_pkg::TARGET_W-1:0]        target;
  logic signed [lcpi_pkg::INTEG_W:0]    integ_raw;
  logic signed [lcpi_pkg::INTEG_W-1:0]  integ_sat;
  logic [lcpi_pkg::MAG_W-1:0]           integ_mag;
  logic [lcpi_pkg::POWER_W-1:0]         power;
  logic                                 shutdown;

  lcpi_pkg::ctl_t ctl_next;
  lcpi_pkg::ctl_t ctl;
  logic           ctl_valid;
  logic           sp_valid;
  logic           advance;
  logic           accept;

  assign advance     = !result.valid || result.ready;
  assign tick.ready  = advance;
  assign accept      = tick.valid && advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_source_mv      <= lcpi_pkg::MIN_SOURCE_RST;
      power_limit        <= lcpi_pkg::POWER_LIMIT_RST;
      setpoint_offset_mv <= lcpi_pkg::OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcpi_pkg::CFG_MIN_SOURCE:  min_source_mv      <= cfg_data[lcpi_pkg::VOLT_W-1:0];
        lcpi_pkg::CFG_POWER_LIMIT: power_limit        <= cfg_data[lcpi_pkg::POWER_W-1:0];
        lcpi_pkg::CFG_OFFSET:      setpoint_offset_mv <= cfg_data[lcpi_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // control stage
  always_comb begin
    en_cmd      = enabled;
    charge_base = charge;
    unique case (tick.data.command)
      lcpi_pkg::CMD_ENABLE:  en_cmd = 1'b1;
      lcpi_pkg::CMD_DISABLE: en_cmd = 1'b0;
      lcpi_pkg::CMD_CLEAR:   charge_base = '0;
      default: ;
    endcase

    target = en_cmd ? tick.data.target_current_ma : '0;

    integ_raw = {integral[lcpi_pkg::INTEG_W-1], integral}
              + $signed({{(lcpi_pkg::INTEG_W+1-lcpi_pkg::TARGET_W){1'b0}}, target})
              - $signed({{(lcpi_pkg::INTEG_W+1-lcpi_pkg::MEAS_W)
                           {tick.data.measured_current_mv[lcpi_pkg::MEAS_W-1]}},
                         tick.data.measured_current_mv});
    if (integ_raw > $signed({lcpi_pkg::INTEG_LIMIT[lcpi_pkg::INTEG_W-1],
                             lcpi_pkg::INTEG_LIMIT})) begin
      integ_sat = lcpi_pkg::INTEG_LIMIT;
    end else if (integ_raw < -$signed({lcpi_pkg::INTEG_LIMIT[lcpi_pkg::INTEG_W-1],
                                      lcpi_pkg::INTEG_LIMIT})) begin
      integ_sat = -lcpi_pkg::INTEG_LIMIT;
    end else begin
      integ_sat = integ_raw[lcpi_pkg::INTEG_W-1:0];
    end
    integ_mag = integ_sat[lcpi_pkg::INTEG_W-1]
              ? lcpi_pkg::MAG_W'(-integ_sat) : lcpi_pkg::MAG_W'(integ_sat);

    power    = {{(lcpi_pkg::POWER_W-lcpi_pkg::VOLT_W){1'b0}}, tick.data.source_voltage_mv}
             * {{(lcpi_pkg::POWER_W-lcpi_pkg::TARGET_W){1'b0}}, target};
    shutdown = (tick.data.source_voltage_mv < min_source_mv) || (power > power_limit);
    enabled_next = en_cmd && !shutdown;

    integral_next = enabled_next ? integ_sat : '0;
    tick_cnt_next = tick_cnt;
    charge_next   = charge_base;
    if (enabled_next) begin
      if (tick_cnt >= TICK_W'(ACCUM_TICKS)) begin
        charge_next   = charge_base
                      + {{(lcpi_pkg::CHARGE_W-lcpi_pkg::MEAS_W)
                          {tick.data.measured_current_mv[lcpi_pkg::MEAS_W-1]}},
                         tick.data.measured_current_mv};
        tick_cnt_next = '0;
      end else begin
        tick_cnt_next = tick_cnt + TICK_W'(1);
      end
    end

    ctl_next.target     = target;
    ctl_next.integ_neg  = integ_sat[lcpi_pkg::INTEG_W-1];
    ctl_next.integ_mag5 = {integ_mag, 2'b00} + {2'b00, integ_mag};
    ctl_next.output_on  = enabled_next;
    ctl_next.charge     = charge_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      integral     <= '0;
      tick_cnt     <= '0;
      charge       <= '0;
      ctl_valid    <= 1'b0;
      sp_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else if (advance) begin
      ctl_valid    <= tick.valid;
      sp_valid     <= ctl_valid;
      result.valid <= sp_valid;
      if (tick.valid) begin
        enabled  <= enabled_next;
        integral <= integral_next;
        tick_cnt <= tick_cnt_next;
        charge   <= charge_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl <= ctl_next;
    end
  end

  lcpi_setpoint u_setpoint (
    .clk     (clk),
    .advance (advance),
    .ctl     (ctl),
    .offset  (setpoint_offset_mv),
    .result  (result.data)
  );

`ifndef SYNTHESIS
  a_integral_range: assert property (@(posedge clk) disable iff (rst)
    integral <= lcpi_pkg::INTEG_LIMIT && integral >= -lcpi_pkg::INTEG_LIMIT)
    else $error("integral outside saturation limits");

  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    tick_cnt <= TICK_W'(ACCUM_TICKS))
    else $error("tick counter past accumulation period");

  a_disable_cmd: assert property (@(posedge clk) disable iff (rst)
    accept && tick.data.command == lcpi_pkg::CMD_DISABLE |=> !enabled && integral == '0)
    else $error("disable request left output enabled");

  a_off_dac_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.output_on |->
      result.data.coarse_dac == '0 && result.data.fine_dac == '0)
    else $error("dac codes nonzero while output off");
`endif

endmodule
